>>> sv/pcmix_pkg.sv
// ----------------------------------------------------------------------------
// pcmix_pkg
// Shared types and constants of the indexed-color mixer.
// ----------------------------------------------------------------------------
package pcmix_pkg;

  localparam int unsigned ChW      = 5;              // RGB555 channel width
  localparam int unsigned RgbW     = 3 * ChW;        // packed RGB555 word
  localparam int unsigned InvAw    = 15;             // inverse table address bits
  localparam int unsigned IdxW     = 8;              // palette index field width

  localparam logic [1:0] REQ_PAL_WR = 2'd0;
  localparam logic [1:0] REQ_INV_WR = 2'd1;
  localparam logic [1:0] REQ_MIX    = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [14:0] entry_index;
    logic [7:0]  raw_red;
    logic [7:0]  raw_green;
    logic [7:0]  raw_blue;
    logic [7:0]  table_value;
    logic [7:0]  color_a;
    logic [7:0]  color_b;
  } pcmix_req_t;

  typedef struct packed {
    logic [7:0] add_color;
    logic [7:0] mul_color;
  } pcmix_res_t;

  // palette write port
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    logic [RgbW-1:0] rgb;
    logic            mapped;
  } pcmix_pal_wr_t;

  // palette read request (two addresses, one enable)
  typedef struct packed {
    logic            re;
    logic [IdxW-1:0] addr_a;
    logic [IdxW-1:0] addr_b;
  } pcmix_pal_rd_t;

endpackage

>>> sv/pcmix_palette_mem.sv
// ----------------------------------------------------------------------------
// pcmix_palette_mem
// Palette store: RGB555 words in a two-read memory plus per-entry mapped
// flags that reset clears. Read data and flags are registered.
// ----------------------------------------------------------------------------
module pcmix_palette_mem
  import pcmix_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pcmix_pal_wr_t   wr_i,
  input  pcmix_pal_rd_t   rd_i,
  output logic [RgbW-1:0] rgb_a_o,
  output logic [RgbW-1:0] rgb_b_o,
  output logic            mapped_a_o,
  output logic            mapped_b_o
);

  localparam int unsigned PalAw = $clog2(PALETTE_ENTRIES);

  logic [RgbW-1:0]            mem_q [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] mapped_q;

  logic [PalAw-1:0] waddr;
  logic [PalAw-1:0] raddr_a;
  logic [PalAw-1:0] raddr_b;

  assign waddr   = wr_i.addr[PalAw-1:0];
  assign raddr_a = rd_i.addr_a[PalAw-1:0];
  assign raddr_b = rd_i.addr_b[PalAw-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[waddr] <= wr_i.rgb;
    end
    if (rd_i.re) begin
      rgb_a_o <= mem_q[raddr_a];
      rgb_b_o <= mem_q[raddr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapped_q   <= '0;
      mapped_a_o <= 1'b0;
      mapped_b_o <= 1'b0;
    end else begin
      if (wr_i.we) begin
        mapped_q[waddr] <= wr_i.mapped;
      end
      if (rd_i.re) begin
        mapped_a_o <= mapped_q[raddr_a];
        mapped_b_o <= mapped_q[raddr_b];
      end
    end
  end

endmodule

>>> sv/pcmix_inverse_mem.sv
// ----------------------------------------------------------------------------
// pcmix_inverse_mem
// RGB555-to-index inverse table, one write and one read per cycle,
// registered read data.
// ----------------------------------------------------------------------------
module pcmix_inverse_mem
  import pcmix_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [InvAw-1:0] waddr_i,
  input  logic [IdxW-1:0]  wdata_i,
  input  logic             re_i,
  input  logic [InvAw-1:0] raddr_i,
  output logic [IdxW-1:0]  rdata_o
);

  localparam int unsigned InvEntries = 1 << InvAw;

  logic [IdxW-1:0] mem_q [InvEntries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> sv/palette_color_add_mul_mixer_unit.sv
// ----------------------------------------------------------------------------
// palette_color_add_mul_mixer_unit
// Indexed-color mixer: palette and inverse-table writes, additive and
// multiplicative mix queries.
// ----------------------------------------------------------------------------
// Writes and unknown requests finish in EXEC; a query with an unmapped operand
// finishes in PAL; other queries run on through INV_ADD, INV_MUL and MUL_DATA,
// and on to BRT when the saturated sum maps to a mapped index. An item is held
// until done, through the inverse table reads (add, mul, brightened add) on its single read port.
// busy is low in the cycle a result is shown, so the next item may follow.
// Reset clears all mapped flags; the receiver cannot stall, so done_o is a
// one-cycle strobe.
module palette_color_add_mul_mixer_unit
  import pcmix_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  pcmix_req_t req_i,
  output logic       done_o,
  output pcmix_res_t res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PAL,
    S_INV_ADD,
    S_INV_MUL,
    S_MUL_DATA,
    S_BRT
  } state_e;

  localparam logic [ChW-1:0] ChMax = {ChW{1'b1}};

  function automatic logic [ChW-1:0] sat_sub(input logic [ChW:0] v, input logic [ChW-1:0] d);
    logic [ChW:0] dd;
    dd = {1'b0, d};
    return (v > dd) ? ChW'(v - dd) : '0;
  endfunction

  function automatic logic [ChW-1:0] brighten(input logic [ChW-1:0] c,
                                              input logic [ChW-1:0] ov);
    logic [2*ChW-1:0] prod;
    prod = (2 * ChW)'(ChMax - c) * (2 * ChW)'(ov);
    return c + ChW'(prod >> 7);
  endfunction

  function automatic logic [ChW-1:0] mul_ch(input logic [ChW-1:0] a, input logic [ChW-1:0] b);
    logic [2*ChW-1:0] prod;
    prod = (2 * ChW)'(a) * (2 * ChW)'(b);
    return prod[2*ChW-1:ChW];
  endfunction

  state_e          state_q;
  pcmix_req_t      req_q;
  logic            a_ok_q, b_ok_q, s_ok_q;
  logic            over_q;
  logic [ChW-1:0]  ov_q;
  logic [InvAw-1:0] mul_addr_q;
  logic [IdxW-1:0] add_q;
  logic [IdxW-1:0] mul_q;
  logic            done_q;
  pcmix_res_t      res_q;

  pcmix_pal_wr_t   pal_wr;
  pcmix_pal_rd_t   pal_rd;
  logic [RgbW-1:0] rgb_a, rgb_b;
  logic            map_a, map_b;

  logic             inv_we;
  logic             inv_re;
  logic [InvAw-1:0] inv_raddr;
  logic [IdxW-1:0]  inv_rdata;

  // query datapath on palette read data
  logic [ChW-1:0] ar, ag, ab, br, bg, bb;
  logic [ChW:0]   sr, sg, sb, mx;
  logic           over;
  logic [ChW-1:0] ov;
  logic [InvAw-1:0] add_addr, mul_addr, brt_addr;
  logic           both_mapped;
  logic           s_mapped;

  assign {ar, ag, ab} = rgb_a;
  assign {br, bg, bb} = rgb_b;
  assign sr = {1'b0, ar} + {1'b0, br};
  assign sg = {1'b0, ag} + {1'b0, bg};
  assign sb = {1'b0, ab} + {1'b0, bb};

  always_comb begin
    mx = sr;
    if (sg > mx) mx = sg;
    if (sb > mx) mx = sb;
  end

  assign over = mx[ChW];
  assign ov   = ChW'(mx - {1'b0, ChMax});

  assign add_addr = over ? {sat_sub(sr, ov), sat_sub(sg, ov), sat_sub(sb, ov)}
                         : {sr[ChW-1:0], sg[ChW-1:0], sb[ChW-1:0]};
  assign mul_addr = {mul_ch(ar, br), mul_ch(ag, bg), mul_ch(ab, bb)};
  assign brt_addr = {brighten(rgb_a[3*ChW-1:2*ChW], ov_q),
                     brighten(rgb_a[2*ChW-1:ChW], ov_q),
                     brighten(rgb_a[ChW-1:0], ov_q)};

  assign both_mapped = map_a && a_ok_q && map_b && b_ok_q;
  assign s_mapped    = map_a && s_ok_q;

  // palette write
  always_comb begin
    pal_wr.we     = (state_q == S_EXEC) && (req_q.req_type == REQ_PAL_WR) &&
                    (req_q.entry_index < 15'(PALETTE_ENTRIES));
    pal_wr.addr   = req_q.entry_index[IdxW-1:0];
    pal_wr.mapped = (req_q.raw_red[7:6] == 2'b00) && (req_q.raw_green[7:6] == 2'b00) &&
                    (req_q.raw_blue[7:6] == 2'b00);
    pal_wr.rgb    = pal_wr.mapped ? {req_q.raw_red[5:1], req_q.raw_green[5:1],
                                     req_q.raw_blue[5:1]} : '0;
  end

  // palette reads: operands in EXEC, additive index in INV_ADD when saturated
  always_comb begin
    pal_rd.re     = 1'b0;
    pal_rd.addr_a = req_q.color_a;
    pal_rd.addr_b = req_q.color_b;
    case (state_q)
      S_EXEC:    pal_rd.re = (req_q.req_type == REQ_MIX);
      S_INV_ADD: begin
        pal_rd.re     = over_q;
        pal_rd.addr_a = inv_rdata;
      end
      default:   pal_rd.re = 1'b0;
    endcase
  end

  // inverse table read port sequence
  always_comb begin
    inv_re    = 1'b0;
    inv_raddr = add_addr;
    case (state_q)
      S_PAL: begin
        inv_re    = both_mapped;
        inv_raddr = add_addr;
      end
      S_INV_ADD: begin
        inv_re    = 1'b1;
        inv_raddr = mul_addr_q;
      end
      S_MUL_DATA: begin
        inv_re    = over_q && s_mapped;
        inv_raddr = brt_addr;
      end
      default: inv_re = 1'b0;
    endcase
  end

  assign inv_we = (state_q == S_EXEC) && (req_q.req_type == REQ_INV_WR);

  pcmix_palette_mem #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_pal (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (pal_wr),
    .rd_i      (pal_rd),
    .rgb_a_o   (rgb_a),
    .rgb_b_o   (rgb_b),
    .mapped_a_o(map_a),
    .mapped_b_o(map_b)
  );

  pcmix_inverse_mem u_inv (
    .clk_i  (clk_i),
    .we_i   (inv_we),
    .waddr_i(req_q.entry_index),
    .wdata_i(req_q.table_value),
    .re_i   (inv_re),
    .raddr_i(inv_raddr),
    .rdata_o(inv_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      req_q      <= '0;
      a_ok_q     <= 1'b0;
      b_ok_q     <= 1'b0;
      s_ok_q     <= 1'b0;
      over_q     <= 1'b0;
      ov_q       <= '0;
      mul_addr_q <= '0;
      add_q      <= '0;
      mul_q      <= '0;
      done_q     <= 1'b0;
      res_q      <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q   <= req_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          a_ok_q <= ({1'b0, req_q.color_a} < 9'(PALETTE_ENTRIES));
          b_ok_q <= ({1'b0, req_q.color_b} < 9'(PALETTE_ENTRIES));
          if (req_q.req_type == REQ_MIX) begin
            state_q <= S_PAL;
          end else begin
            res_q   <= '0;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_PAL: begin
          over_q     <= over;
          ov_q       <= ov;
          mul_addr_q <= mul_addr;
          if (both_mapped) begin
            state_q <= S_INV_ADD;
          end else begin
            // unmapped operand: pass the other color through
            res_q.add_color <= (map_b && b_ok_q) ? req_q.color_b : req_q.color_a;
            res_q.mul_color <= (map_b && b_ok_q) ? req_q.color_b : req_q.color_a;
            done_q          <= 1'b1;
            state_q         <= S_IDLE;
          end
        end
        S_INV_ADD: begin
          add_q   <= inv_rdata;
          s_ok_q  <= ({1'b0, inv_rdata} < 9'(PALETTE_ENTRIES));
          state_q <= S_INV_MUL;
        end
        S_INV_MUL: state_q <= S_MUL_DATA;
        S_MUL_DATA: begin
          mul_q <= inv_rdata;
          if (over_q && s_mapped) begin
            state_q <= S_BRT;
          end else begin
            res_q.add_color <= over_q ? '0 : add_q;
            res_q.mul_color <= inv_rdata;
            done_q          <= 1'b1;
            state_q         <= S_IDLE;
          end
        end
        S_BRT: begin
          res_q.add_color <= inv_rdata;
          res_q.mul_color <= mul_q;
          done_q          <= 1'b1;
          state_q         <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> sim/palette_color_add_mul_mixer_unit_test.sv
// ----------------------------------------------------------------------------
// palette_color_add_mul_mixer_unit_test
// Self-checking bench for the indexed-color mixer. A directed table walks
// reset state, palette and inverse-table write corners, unmapped operands,
// saturation and unknown requests. Random palette writes, inverse writes and
// mix queries follow. Typed rows are scored against their own colors, the rest
// against the in-bench color predictor. Any inverse entry a query reads is written first.
// ----------------------------------------------------------------------------
module palette_color_add_mul_mixer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pcmix_pkg::*;

  localparam int          HalfPeriod = 5;
  localparam int          PalEntries = 256;
  localparam int          InvDepth   = 1 << InvAw;
  localparam int          ChMax      = 31;
  localparam int          BrightSh   = 7;
  localparam int          MulSh      = 5;
  localparam logic [7:0]  RawMax     = 8'd63;
  localparam logic [1:0]  ReqUnused  = 2'd3;
  localparam int          SendItems  = 650;
  localparam int          IdlePct    = 8;
  localparam int          TailCycles = 16;
  localparam int          DrainEvery = 160;

  typedef struct {
    pcmix_req_t rq;
    bit         typed;
    logic [7:0] add_c;
    logic [7:0] mul_c;
  } row_t;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start  = 1'b0;
  pcmix_req_t req_i  = '0;
  logic       busy;
  logic       done_o;
  pcmix_res_t res_o;

  // predicted block state
  bit [RgbW-1:0] pal_rgb    [PalEntries];
  bit            pal_mapped [PalEntries];
  bit [7:0]      inv_map    [InvDepth];
  bit            inv_written[InvDepth];
  logic [InvAw-1:0] seeded_addrs[$];

  pcmix_res_t pending_colors[$];
  pcmix_res_t head_color;
  int         n_fail  = 0;
  int         n_sent  = 0;
  bit         no_idle = 1'b0;

  palette_color_add_mul_mixer_unit #(
    .PALETTE_ENTRIES(PalEntries)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("FAIL palette_color_add_mul_mixer_unit");
    $finish;
  end

  function automatic bit is_mapped(input logic [7:0] idx);
    return (int'(idx) < PalEntries) && pal_mapped[idx];
  endfunction

  // k: 2 red, 1 green, 0 blue
  function automatic int chan(input logic [RgbW-1:0] w, input int k);
    logic [RgbW-1:0] t;
    t = w >> (ChW * k);
    return int'(t[ChW-1:0]);
  endfunction

  // first unwritten entry touched is reported through gap
  function automatic logic [7:0] inv_read(input int r, input int g, input int b,
                                          inout int gap);
    logic [InvAw-1:0] a;
    a = {ChW'(r), ChW'(g), ChW'(b)};
    if (!inv_written[a] && gap < 0) gap = int'(a);
    return inv_map[a];
  endfunction

  function automatic pcmix_res_t mix_colors(input logic [7:0] ca, input logic [7:0] cb,
                                            output int gap);
    pcmix_res_t res;
    int         a[3], b[3], sum[3], c[3];
    int         top, ov;
    logic [7:0] s;
    gap = -1;
    res = '0;
    if (is_mapped(ca) && is_mapped(cb)) begin
      top = 0;
      for (int k = 0; k < 3; k++) begin
        a[k]   = chan(pal_rgb[ca], k);
        b[k]   = chan(pal_rgb[cb], k);
        sum[k] = a[k] + b[k];
        if (sum[k] > top) top = sum[k];
      end
      if (top <= ChMax) begin
        res.add_color = inv_read(sum[2], sum[1], sum[0], gap);
      end else begin
        // saturate: shift every channel down by the overflow, then brighten
        ov = top - ChMax;
        for (int k = 0; k < 3; k++) c[k] = (sum[k] > ov) ? sum[k] - ov : 0;
        s = inv_read(c[2], c[1], c[0], gap);
        if (is_mapped(s)) begin
          for (int k = 0; k < 3; k++) begin
            c[k] = chan(pal_rgb[s], k);
            c[k] = c[k] + (((ChMax - c[k]) * ov) >> BrightSh);
          end
          res.add_color = inv_read(c[2], c[1], c[0], gap);
        end else begin
          res.add_color = '0;
        end
      end
      res.mul_color = inv_read((a[2] * b[2]) >> MulSh, (a[1] * b[1]) >> MulSh,
                               (a[0] * b[0]) >> MulSh, gap);
    end else if (is_mapped(cb)) begin
      res = {cb, cb};
    end else begin
      res = {ca, ca};
    end
    return res;
  endfunction

  function automatic pcmix_res_t predict_colors(input pcmix_req_t rq);
    pcmix_res_t res;
    int         gap;
    res = '0;
    case (rq.req_type)
      REQ_PAL_WR: begin
        if (int'(rq.entry_index) < PalEntries) begin
          if (rq.raw_red <= RawMax && rq.raw_green <= RawMax && rq.raw_blue <= RawMax) begin
            pal_rgb[rq.entry_index[IdxW-1:0]] =
              {rq.raw_red[5:1], rq.raw_green[5:1], rq.raw_blue[5:1]};
            pal_mapped[rq.entry_index[IdxW-1:0]] = 1'b1;
          end else begin
            pal_rgb[rq.entry_index[IdxW-1:0]]    = '0;
            pal_mapped[rq.entry_index[IdxW-1:0]] = 1'b0;
          end
        end
      end
      REQ_INV_WR: begin
        inv_map[rq.entry_index]     = rq.table_value;
        inv_written[rq.entry_index] = 1'b1;
      end
      REQ_MIX: res = mix_colors(rq.color_a, rq.color_b, gap);
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] pick_color();
    if ($urandom_range(99) < 75) return 8'($urandom_range(15));
    return 8'($urandom_range(255));
  endfunction

  function automatic row_t mk_row(input logic [1:0] kind, input int idx, input int r,
                                  input int g, input int b, input int tv, input int ca,
                                  input int cb, input bit typed, input int add_c,
                                  input int mul_c);
    row_t row;
    row.rq.req_type    = kind;
    row.rq.entry_index = 15'(idx);
    row.rq.raw_red     = 8'(r);
    row.rq.raw_green   = 8'(g);
    row.rq.raw_blue    = 8'(b);
    row.rq.table_value = 8'(tv);
    row.rq.color_a     = 8'(ca);
    row.rq.color_b     = 8'(cb);
    row.typed          = typed;
    row.add_c          = 8'(add_c);
    row.mul_c          = 8'(mul_c);
    return row;
  endfunction

  function automatic pcmix_req_t random_req();
    pcmix_req_t rq;
    int         k;
    // don't-care fields carry noise too
    rq.entry_index = 15'($urandom);
    rq.raw_red     = 8'($urandom);
    rq.raw_green   = 8'($urandom);
    rq.raw_blue    = 8'($urandom);
    rq.table_value = 8'($urandom);
    rq.color_a     = 8'($urandom);
    rq.color_b     = 8'($urandom);
    k = $urandom_range(99);
    if (k < 30) begin
      rq.req_type = REQ_PAL_WR;
      k = $urandom_range(99);
      if (k < 70) rq.entry_index = 15'($urandom_range(15));
      else if (k < 90) rq.entry_index = 15'($urandom_range(255));
      if ($urandom_range(99) < 85) begin
        rq.raw_red   = 8'($urandom_range(63));
        rq.raw_green = 8'($urandom_range(63));
        rq.raw_blue  = 8'($urandom_range(63));
      end
    end else if (k < 50) begin
      rq.req_type    = REQ_INV_WR;
      rq.table_value = pick_color();
      if (seeded_addrs.size() != 0 && $urandom_range(1) == 1)
        rq.entry_index = seeded_addrs[$urandom_range(seeded_addrs.size() - 1)];
    end else if (k < 95) begin
      rq.req_type = REQ_MIX;
      rq.color_a  = pick_color();
      rq.color_b  = pick_color();
    end else begin
      rq.req_type = ReqUnused;
    end
    return rq;
  endfunction

  task automatic issue_request(input pcmix_req_t rq, input bit typed,
                               input pcmix_res_t typed_res);
    pcmix_res_t want;
    if (!no_idle && $urandom_range(99) < IdlePct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    // transfer taken at this edge
    want = predict_colors(rq);
    pending_colors.push_back(typed ? typed_res : want);
    n_sent++;
  endtask

  // write every inverse entry that the query would read and nobody wrote yet
  task automatic seed_inverse_entries(input logic [7:0] ca, input logic [7:0] cb);
    pcmix_req_t rq;
    pcmix_res_t unused;
    int         gap;
    unused = mix_colors(ca, cb, gap);
    while (gap >= 0) begin
      rq             = random_req();
      rq.req_type    = REQ_INV_WR;
      rq.entry_index = 15'(gap);
      rq.table_value = pick_color();
      seeded_addrs.push_back(15'(gap));
      issue_request(rq, 1'b0, '0);
      unused = mix_colors(ca, cb, gap);
    end
  endtask

  task automatic wait_all_colors();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_colors.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected result, expected none, got add=%0d mul=%0d",
                 $time, res_o.add_color, res_o.mul_color);
        n_fail++;
      end else begin
        head_color = pending_colors.pop_front();
        if (res_o.add_color !== head_color.add_color) begin
          $display("%0t: add_color expected %0d, got %0d",
                   $time, head_color.add_color, res_o.add_color);
          n_fail++;
        end
        if (res_o.mul_color !== head_color.mul_color) begin
          $display("%0t: mul_color expected %0d, got %0d",
                   $time, head_color.mul_color, res_o.mul_color);
          n_fail++;
        end
      end
    end
  end

  initial begin
    row_t       rows[$];
    pcmix_req_t rq;
    int         n;

    //                     kind        idx     r    g    b   tv   ca   cb  typed add mul
    rows.push_back(mk_row(REQ_MIX,      0,      0,   0,   0,   0,   5,   9, 1,   5,  5));
    rows.push_back(mk_row(ReqUnused,    'h7FFF, 255, 255, 255, 255, 255, 255, 1, 0, 0));
    rows.push_back(mk_row(REQ_PAL_WR,   0,      0,   0,   0,   0,   0,   0, 1,   0,  0));
    rows.push_back(mk_row(REQ_PAL_WR,   255,    63,  63,  63,  0,   0,   0, 1,   0,  0));
    // any channel above 63 leaves the entry unmapped
    rows.push_back(mk_row(REQ_PAL_WR,   1,      64,  0,   0,   0,   0,   0, 1,   0,  0));
    rows.push_back(mk_row(REQ_PAL_WR,   2,      0,   255, 0,   0,   0,   0, 1,   0,  0));
    rows.push_back(mk_row(REQ_PAL_WR,   3,      0,   0,   128, 0,   0,   0, 1,   0,  0));
    // beyond the palette: ignored
    rows.push_back(mk_row(REQ_PAL_WR,   'h7FFF, 10,  20,  30,  0,   0,   0, 1,   0,  0));
    rows.push_back(mk_row(REQ_PAL_WR,   256,    1,   2,   3,   0,   0,   0, 1,   0,  0));
    rows.push_back(mk_row(REQ_INV_WR,   'h7FFF, 0,   0,   0,   255, 0,   0, 1,   0,  0));
    rows.push_back(mk_row(REQ_INV_WR,   0,      0,   0,   0,   0,   0,   0, 1,   0,  0));
    // one operand unmapped, then both
    rows.push_back(mk_row(REQ_MIX,      0,      0,   0,   0,   0,   1,   255, 1, 255, 255));
    rows.push_back(mk_row(REQ_MIX,      0,      0,   0,   0,   0,   255, 1,   1, 255, 255));
    rows.push_back(mk_row(REQ_MIX,      0,      0,   0,   0,   0,   2,   3,   1, 2,   2));
    rows.push_back(mk_row(REQ_MIX,      0,      0,   0,   0,   0,   0,   0,   0, 0,   0));
    rows.push_back(mk_row(REQ_MIX,      0,      0,   0,   0,   0,   255, 255, 0, 0,   0));
    rows.push_back(mk_row(REQ_MIX,      0,      0,   0,   0,   0,   0,   255, 0, 0,   0));
    rows.push_back(mk_row(REQ_PAL_WR,   4,      63,  0,   0,   0,   0,   0,   1, 0,   0));
    // saturated red lands on an unmapped index, then on a mapped one
    rows.push_back(mk_row(REQ_INV_WR,   'h7C00, 0,   0,   0,   1,   0,   0,   1, 0,   0));
    rows.push_back(mk_row(REQ_MIX,      0,      0,   0,   0,   0,   4,   255, 0, 0,   0));
    rows.push_back(mk_row(REQ_INV_WR,   'h7C00, 0,   0,   0,   4,   0,   0,   1, 0,   0));
    rows.push_back(mk_row(REQ_MIX,      0,      0,   0,   0,   0,   4,   255, 0, 0,   0));
    rows.push_back(mk_row(REQ_PAL_WR,   5,      20,  40,  10,  0,   0,   0,   1, 0,   0));
    rows.push_back(mk_row(REQ_MIX,      0,      0,   0,   0,   0,   5,   4,   0, 0,   0));
    rows.push_back(mk_row(REQ_PAL_WR,   255,    70,  0,   0,   0,   0,   0,   1, 0,   0));
    rows.push_back(mk_row(REQ_MIX,      0,      0,   0,   0,   0,   0,   255, 1, 0,   0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].rq.req_type == REQ_MIX)
        seed_inverse_entries(rows[i].rq.color_a, rows[i].rq.color_b);
      issue_request(rows[i].rq, rows[i].typed, {rows[i].add_c, rows[i].mul_c});
    end
    wait_all_colors();

    // seeding writes count toward the item budget
    n = 0;
    while (n_sent < SendItems) begin
      no_idle = (n_sent >= 250 && n_sent < 430);
      rq = random_req();
      if (rq.req_type == REQ_MIX) seed_inverse_entries(rq.color_a, rq.color_b);
      issue_request(rq, 1'b0, '0);
      if (n % DrainEvery == DrainEvery - 1) wait_all_colors();
      n++;
    end
    wait_all_colors();
    repeat (TailCycles) @(posedge clk_i);

    if (n_fail == 0 && pending_colors.size() == 0) begin
      $display("PASS palette_color_add_mul_mixer_unit");
    end else begin
      $display("FAIL palette_color_add_mul_mixer_unit");
    end
    $finish;
  end

endmodule

>>> palette_color_add_mul_mixer_unit.f
sv/pcmix_pkg.sv
sv/pcmix_palette_mem.sv
sv/pcmix_inverse_mem.sv
sv/palette_color_add_mul_mixer_unit.sv
sim/palette_color_add_mul_mixer_unit_test.sv
